/* hdl/stt_pkg.sv */
// shared types, byte codes and byte classification for the source text tokenizer
package stt_pkg;

    localparam int OUT_WIDTH = 16;
    localparam logic [OUT_WIDTH-1:0] OUT_MAX = '1;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_NUMBER, M_MERGE, M_SLASH, M_LINEC, M_BLOCK, M_BSTAR, M_ERROR
    } t_mode;

    typedef enum logic [1:0] {EV_BYTE, EV_DONE, EV_ILLEGAL, EV_EOF} t_event;

    typedef enum logic [1:0] {TC_IDENT, TC_NUMBER, TC_SYMBOL, TC_EOF} t_class;

    typedef enum logic [2:0] {
        BC_BLANK, BC_ALPHA, BC_DIGIT, BC_SINGLE, BC_SLASH, BC_MERGE, BC_OTHER
    } t_byte_class;

    typedef struct packed {
        t_event      kind;
        t_class      cls;
        logic [7:0]  ch;
        logic        use_cur;
    } t_rec;

    typedef struct packed {
        t_rec [3:0]           rec;
        logic [1:0]           last_idx;
        logic [OUT_WIDTH-1:0] held_line;
        logic [OUT_WIDTH-1:0] held_col;
        logic [OUT_WIDTH-1:0] cur_line;
        logic [OUT_WIDTH-1:0] cur_col;
    } t_bundle;

    function automatic logic is_merge(input logic [7:0] b);
        return b == 8'h3A || b == 8'h3D || b == 8'h2B || b == 8'h2D || b == CH_STAR ||
               b == CH_SLASH || b == 8'h3C || b == 8'h3E || b == 8'h26 || b == 8'h7C;
    endfunction

    function automatic t_byte_class classify(input logic [7:0] b);
        t_byte_class c;
        if (b == CH_SPACE || b == CH_LF || b == CH_CR || b == CH_TAB) begin
            c = BC_BLANK;
        end else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
            c = BC_ALPHA;
        end else if (b >= 8'h30 && b <= 8'h39) begin
            c = BC_DIGIT;
        end else if (b == 8'h28 || b == 8'h29 || b == 8'h7B || b == 8'h7D ||
                     b == 8'h5B || b == 8'h5D || b == 8'h2C) begin
            c = BC_SINGLE;
        end else if (b == CH_SLASH) begin
            c = BC_SLASH;
        end else if (is_merge(b)) begin
            c = BC_MERGE;
        end else begin
            c = BC_OTHER;
        end
        return c;
    endfunction

    function automatic t_rec mk_rec(input t_event kind, input t_class cls,
                                    input logic [7:0] ch, input logic use_cur);
        t_rec r;
        r.kind    = kind;
        r.cls     = cls;
        r.ch      = ch;
        r.use_cur = use_cur;
        return r;
    endfunction

endpackage

/* hdl/stt_front.sv */
// lexer front end: classifies each request and builds its bundle of results
module stt_front
    import stt_pkg::*;
#(
    parameter int LINE_WIDTH   = 16,
    parameter int COLUMN_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_bundle_push,
    output t_bundle    o_bundle
);

    t_mode                   r_mode, n_mode;
    logic [LINE_WIDTH-1:0]   r_line, n_line, r_hl, n_hl;
    logic [COLUMN_WIDTH-1:0] r_col, n_col, r_hc, n_hc;

    t_byte_class bc;
    logic        restart;
    logic        fits;
    t_class      run_cls;
    logic [2:0]  k;
    t_bundle     bnd;
    logic [31:0] w_line, w_col, w_hl, w_hc;

    assign bc = classify(i_in_byte);

    always_comb begin
        case (r_mode)
            M_WORD:   fits = (bc == BC_ALPHA);
            M_NUMBER: fits = (bc == BC_DIGIT) || (i_in_byte == CH_DOT);
            M_MERGE:  fits = is_merge(i_in_byte);
            default:  fits = 1'b0;
        endcase
        case (r_mode)
            M_WORD:   run_cls = TC_IDENT;
            M_NUMBER: run_cls = TC_NUMBER;
            default:  run_cls = TC_SYMBOL;
        endcase
        case (r_mode)
            M_IDLE:                    restart = 1'b1;
            M_WORD, M_NUMBER, M_MERGE: restart = !fits;
            M_SLASH:                   restart = (i_in_byte != CH_STAR) && !is_merge(i_in_byte);
            default:                   restart = 1'b0;
        endcase
    end

    // next state and position
    always_comb begin
        n_mode = r_mode;
        n_line = r_line;
        n_col  = r_col;
        n_hl   = r_hl;
        n_hc   = r_hc;
        if (i_end_of_input) begin
            n_mode = M_IDLE;
            n_line = LINE_WIDTH'(1);
            n_col  = COLUMN_WIDTH'(1);
            n_hl   = LINE_WIDTH'(1);
            n_hc   = COLUMN_WIDTH'(1);
        end else begin
            case (r_mode)
                M_SLASH: begin
                    if (i_in_byte == CH_SLASH) begin
                        n_mode = M_LINEC;
                    end else if (i_in_byte == CH_STAR) begin
                        n_mode = M_BSTAR;
                    end else if (is_merge(i_in_byte)) begin
                        n_mode = M_MERGE;
                    end
                end
                M_LINEC: begin
                    if (i_in_byte == CH_LF) begin
                        n_mode = M_IDLE;
                    end
                end
                M_BLOCK: begin
                    if (i_in_byte == CH_STAR) begin
                        n_mode = M_BSTAR;
                    end
                end
                M_BSTAR: begin
                    n_mode = (i_in_byte == CH_SLASH) ? M_IDLE : M_BLOCK;
                end
                M_IDLE, M_WORD, M_NUMBER, M_MERGE, M_ERROR: begin
                    n_mode = r_mode;
                end
                default: begin
                    n_mode = M_ERROR;
                end
            endcase
            if (restart) begin
                case (bc)
                    BC_ALPHA:  n_mode = M_WORD;
                    BC_DIGIT:  n_mode = M_NUMBER;
                    BC_SLASH:  n_mode = M_SLASH;
                    BC_MERGE:  n_mode = M_MERGE;
                    BC_OTHER:  n_mode = M_ERROR;
                    default:   n_mode = M_IDLE;
                endcase
                if (bc != BC_BLANK && bc != BC_OTHER) begin
                    n_hl = r_line;
                    n_hc = r_col;
                end
            end
            if (!(r_mode == M_ERROR || (restart && bc == BC_OTHER))) begin
                if (i_in_byte == CH_LF) begin
                    n_col = COLUMN_WIDTH'(1);
                    if (r_line != '1) begin
                        n_line = r_line + LINE_WIDTH'(1);
                    end
                end else if (r_col != '1) begin
                    n_col = r_col + COLUMN_WIDTH'(1);
                end
            end
        end
    end

    // result bundle
    always_comb begin
        bnd.rec = '0;
        k       = 3'd0;
        if (i_end_of_input) begin
            case (r_mode)
                M_WORD, M_NUMBER, M_MERGE: begin
                    bnd.rec[k[1:0]] = mk_rec(EV_DONE, run_cls, 8'd0, 1'b0);
                    k = k + 3'd1;
                end
                M_SLASH: begin
                    bnd.rec[k[1:0]] = mk_rec(EV_BYTE, TC_SYMBOL, CH_SLASH, 1'b0);
                    k = k + 3'd1;
                    bnd.rec[k[1:0]] = mk_rec(EV_DONE, TC_SYMBOL, 8'd0, 1'b0);
                    k = k + 3'd1;
                end
                default: begin
                    k = k;
                end
            endcase
            bnd.rec[k[1:0]] = mk_rec(EV_EOF, TC_EOF, 8'd0, 1'b1);
            k = k + 3'd1;
        end else begin
            if (r_mode == M_WORD || r_mode == M_NUMBER || r_mode == M_MERGE) begin
                if (fits) begin
                    bnd.rec[k[1:0]] = mk_rec(EV_BYTE, run_cls, i_in_byte, 1'b0);
                end else begin
                    bnd.rec[k[1:0]] = mk_rec(EV_DONE, run_cls, 8'd0, 1'b0);
                end
                k = k + 3'd1;
            end
            if (r_mode == M_SLASH && i_in_byte != CH_SLASH && i_in_byte != CH_STAR) begin
                bnd.rec[k[1:0]] = mk_rec(EV_BYTE, TC_SYMBOL, CH_SLASH, 1'b0);
                k = k + 3'd1;
                if (is_merge(i_in_byte)) begin
                    bnd.rec[k[1:0]] = mk_rec(EV_BYTE, TC_SYMBOL, i_in_byte, 1'b0);
                end else begin
                    bnd.rec[k[1:0]] = mk_rec(EV_DONE, TC_SYMBOL, 8'd0, 1'b0);
                end
                k = k + 3'd1;
            end
            if (restart) begin
                case (bc)
                    BC_ALPHA: begin
                        bnd.rec[k[1:0]] = mk_rec(EV_BYTE, TC_IDENT, i_in_byte, 1'b1);
                        k = k + 3'd1;
                    end
                    BC_DIGIT: begin
                        bnd.rec[k[1:0]] = mk_rec(EV_BYTE, TC_NUMBER, i_in_byte, 1'b1);
                        k = k + 3'd1;
                    end
                    BC_MERGE: begin
                        bnd.rec[k[1:0]] = mk_rec(EV_BYTE, TC_SYMBOL, i_in_byte, 1'b1);
                        k = k + 3'd1;
                    end
                    BC_SINGLE: begin
                        bnd.rec[k[1:0]] = mk_rec(EV_BYTE, TC_SYMBOL, i_in_byte, 1'b1);
                        k = k + 3'd1;
                        bnd.rec[k[1:0]] = mk_rec(EV_DONE, TC_SYMBOL, 8'd0, 1'b1);
                        k = k + 3'd1;
                    end
                    BC_OTHER: begin
                        bnd.rec[k[1:0]] = mk_rec(EV_ILLEGAL, TC_IDENT, i_in_byte, 1'b1);
                        k = k + 3'd1;
                    end
                    default: begin
                        k = k;
                    end
                endcase
            end
        end
        bnd.last_idx = k[1:0] - 2'd1;
        w_line = 32'(r_line);
        w_col  = 32'(r_col);
        w_hl   = 32'(r_hl);
        w_hc   = 32'(r_hc);
        bnd.cur_line  = (w_line > 32'(OUT_MAX)) ? OUT_MAX : w_line[OUT_WIDTH-1:0];
        bnd.cur_col   = (w_col  > 32'(OUT_MAX)) ? OUT_MAX : w_col[OUT_WIDTH-1:0];
        bnd.held_line = (w_hl   > 32'(OUT_MAX)) ? OUT_MAX : w_hl[OUT_WIDTH-1:0];
        bnd.held_col  = (w_hc   > 32'(OUT_MAX)) ? OUT_MAX : w_hc[OUT_WIDTH-1:0];
    end

    assign o_bundle      = bnd;
    assign o_bundle_push = i_accept && (k != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_line <= LINE_WIDTH'(1);
            r_col  <= COLUMN_WIDTH'(1);
            r_hl   <= LINE_WIDTH'(1);
            r_hc   <= COLUMN_WIDTH'(1);
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
            r_hl   <= n_hl;
            r_hc   <= n_hc;
        end
    end

endmodule

/* hdl/stt_queue.sv */
// short bundle queue between the lexer front end and the result back end
module stt_queue
    import stt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_bundle o_head
);

    t_bundle      r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (QAW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* hdl/stt_back.sv */
// result back end: hands out the records of the head bundle one at a time
module stt_back
    import stt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  t_bundle              i_head,
    input  logic                 i_pop,
    output logic                 o_q_pop,
    output logic [1:0]           o_event_kind,
    output logic [1:0]           o_token_class,
    output logic [7:0]           o_char_value,
    output logic [OUT_WIDTH-1:0] o_start_line,
    output logic [OUT_WIDTH-1:0] o_start_column,
    output logic                 o_last_result
);

    logic [1:0] r_idx;
    t_rec       sel;
    logic       last;
    logic       take;

    assign sel  = i_head.rec[r_idx];
    assign last = (r_idx == i_head.last_idx);
    assign take = i_pop && !i_q_empty;

    assign o_event_kind   = sel.kind;
    assign o_token_class  = sel.cls;
    assign o_char_value   = sel.ch;
    assign o_start_line   = sel.use_cur ? i_head.cur_line : i_head.held_line;
    assign o_start_column = sel.use_cur ? i_head.cur_col : i_head.held_col;
    assign o_last_result  = last;
    assign o_q_pop        = take && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

/* hdl/source_text_tokenizer.sv */
// top level of the source text tokenizer
// results of a request are registered in the bundle queue and reach the result side behind any earlier bundles
// throughput: one request per cycle while the four-entry bundle queue has room
// results leave at one per cycle while pop is asserted, so requests giving up to four results pace the input
// reset: synchronous; position returns to line 1 column 1, lexer idle, queue emptied
module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int LINE_WIDTH   = 16,
    parameter int COLUMN_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_event_kind,
    output logic [1:0]  o_token_class,
    output logic [7:0]  o_char_value,
    output logic [15:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic        o_last_result
);

    logic    accept;
    logic    bundle_push;
    t_bundle bundle;
    t_bundle head;
    logic    q_pop;

    assign accept = push && !full;

    stt_front #(
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_bundle_push  (bundle_push),
        .o_bundle       (bundle)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bundle_push),
        .i_data  (bundle),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    stt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (empty),
        .i_head         (head),
        .i_pop          (pop),
        .o_q_pop        (q_pop),
        .o_event_kind   (o_event_kind),
        .o_token_class  (o_token_class),
        .o_char_value   (o_char_value),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_last_result  (o_last_result)
    );

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queue not cleared by reset");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("full and empty together");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_event_kind == EV_EOF || o_event_kind == EV_ILLEGAL)) |-> o_last_result)
        else $error("eof or illegal event not last of its request");

    a_eof_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event_kind == EV_EOF) |-> (o_token_class == TC_EOF && o_start_line != '0))
        else $error("eof event with wrong class or line");

endmodule
